>>> rtl/hcp_pkg.sv
// Package for the hardware cursor positioner: widths, register indexes, codes and payload types.
package hcp_pkg;

    localparam int COORD_BITS    = 12;
    localparam int CURSOR_SIZE   = 64;
    localparam int HOT_BITS      = 6;
    localparam int VIS_BITS      = 12;
    localparam int VIRT_BITS     = 13;
    localparam int PSC_BITS      = 2;
    localparam int ORIGIN_BITS   = 11;
    localparam int OFFSET_BITS   = 6;
    localparam int START_BITS    = 20;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 13;
    localparam int ORIGIN_MAX    = 2047;

    localparam logic [7:0] EVEN_MASK = 8'hFE;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_BLOCKED        = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOT_X          = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOT_Y          = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_VISIBLE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_VISIBLE_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIRTUAL_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_SIZE     = 3'd6;

    // Pixel size codes
    localparam logic [PSC_BITS-1:0] PSC_ONE  = 2'd0;
    localparam logic [PSC_BITS-1:0] PSC_TWO  = 2'd1;
    localparam logic [PSC_BITS-1:0] PSC_FOUR = 2'd2;

    // Register reset values
    localparam logic [VIS_BITS-1:0]  VIS_WIDTH_RESET  = 12'd640;
    localparam logic [VIS_BITS-1:0]  VIS_HEIGHT_RESET = 12'd480;
    localparam logic [VIRT_BITS-1:0] VIRT_WIDTH_RESET = 13'd640;

    typedef struct packed {
        logic                 blocked;
        logic [HOT_BITS-1:0]  hot_x;
        logic [HOT_BITS-1:0]  hot_y;
        logic [VIS_BITS-1:0]  visible_width;
        logic [VIS_BITS-1:0]  visible_height;
        logic [VIRT_BITS-1:0] virtual_width;
        logic [PSC_BITS-1:0]  pixel_size_code;
    } cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pointer_x;
        logic [COORD_BITS-1:0] pointer_y;
    } in_t;

    typedef struct packed {
        logic                   updated;
        logic [ORIGIN_BITS-1:0] origin_x;
        logic [ORIGIN_BITS-1:0] origin_y;
        logic [OFFSET_BITS-1:0] start_offset_x;
        logic [OFFSET_BITS-1:0] start_offset_y;
        logic                   pan_changed;
        logic [START_BITS-1:0]  display_start;
    } out_t;

    // Item after the pan update, passed to the result stage
    typedef struct packed {
        logic                  blocked;
        logic                  changed;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] pan_col;
        logic [COORD_BITS-1:0] pan_row;
    } pan_item_t;

endpackage

>>> rtl/hcp_cfg_regs.sv
// Configuration register file of the cursor positioner.
module hcp_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [hcp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [hcp_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data,
    output hcp_pkg::cfg_t                        cfg
);

    hcp_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blocked         <= 1'b0;
            cfg_reg.hot_x           <= '0;
            cfg_reg.hot_y           <= '0;
            cfg_reg.visible_width   <= hcp_pkg::VIS_WIDTH_RESET;
            cfg_reg.visible_height  <= hcp_pkg::VIS_HEIGHT_RESET;
            cfg_reg.virtual_width   <= hcp_pkg::VIRT_WIDTH_RESET;
            cfg_reg.pixel_size_code <= hcp_pkg::PSC_ONE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                hcp_pkg::REG_BLOCKED: begin
                    cfg_reg.blocked <= cfg_wr_data[0];
                end
                hcp_pkg::REG_HOT_X: begin
                    cfg_reg.hot_x <= cfg_wr_data[hcp_pkg::HOT_BITS-1:0];
                end
                hcp_pkg::REG_HOT_Y: begin
                    cfg_reg.hot_y <= cfg_wr_data[hcp_pkg::HOT_BITS-1:0];
                end
                hcp_pkg::REG_VISIBLE_WIDTH: begin
                    cfg_reg.visible_width <= cfg_wr_data[hcp_pkg::VIS_BITS-1:0];
                end
                hcp_pkg::REG_VISIBLE_HEIGHT: begin
                    cfg_reg.visible_height <= cfg_wr_data[hcp_pkg::VIS_BITS-1:0];
                end
                hcp_pkg::REG_VIRTUAL_WIDTH: begin
                    cfg_reg.virtual_width <= cfg_wr_data[hcp_pkg::VIRT_BITS-1:0];
                end
                hcp_pkg::REG_PIXEL_SIZE: begin
                    cfg_reg.pixel_size_code <= cfg_wr_data[hcp_pkg::PSC_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/hcp_pan_stage.sv
// Viewport pan update and first pipeline register of the cursor positioner.
module hcp_pan_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  hcp_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  hcp_pkg::in_t        in_data,
    output logic                item_valid,
    input  logic                item_ready,
    output hcp_pkg::pan_item_t  item
);

    localparam int CB = hcp_pkg::COORD_BITS;
    localparam int CMP_BITS = ((hcp_pkg::COORD_BITS > hcp_pkg::VIS_BITS) ?
                               hcp_pkg::COORD_BITS : hcp_pkg::VIS_BITS) + 1;

    logic [CB-1:0]       pan_col_reg, pan_row_reg;
    logic                item_valid_reg;
    hcp_pkg::pan_item_t  item_reg;

    logic                col_lt, col_ge, row_lt, row_ge;
    logic [CB-1:0]       col_a, row_a, pan_col_next, pan_row_next;
    logic [CMP_BITS-1:0] col_lim, row_lim, col_wrap, row_wrap;
    logic                accept;

    // Left, right, top, bottom in order; each check sees the earlier result
    always_comb begin
        col_lt   = in_data.pointer_x < pan_col_reg;
        col_a    = col_lt ? in_data.pointer_x : pan_col_reg;
        col_lim  = CMP_BITS'(col_a) + CMP_BITS'(cfg.visible_width);
        col_ge   = CMP_BITS'(in_data.pointer_x) >= col_lim;
        col_wrap = CMP_BITS'(in_data.pointer_x) + CMP_BITS'(1)
                   - CMP_BITS'(cfg.visible_width);
        pan_col_next = col_ge ? col_wrap[CB-1:0] : col_a;

        row_lt   = in_data.pointer_y < pan_row_reg;
        row_a    = row_lt ? in_data.pointer_y : pan_row_reg;
        row_lim  = CMP_BITS'(row_a) + CMP_BITS'(cfg.visible_height);
        row_ge   = CMP_BITS'(in_data.pointer_y) >= row_lim;
        row_wrap = CMP_BITS'(in_data.pointer_y) + CMP_BITS'(1)
                   - CMP_BITS'(cfg.visible_height);
        pan_row_next = row_ge ? row_wrap[CB-1:0] : row_a;
    end

    assign in_ready = !item_valid_reg || item_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            pan_col_reg    <= '0;
            pan_row_reg    <= '0;
        end else begin
            if (in_ready) begin
                item_valid_reg <= in_valid;
            end
            if (accept && !cfg.blocked) begin
                pan_col_reg <= pan_col_next;
                pan_row_reg <= pan_row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.blocked <= cfg.blocked;
            item_reg.changed <= col_lt || col_ge || row_lt || row_ge;
            item_reg.x       <= in_data.pointer_x;
            item_reg.y       <= in_data.pointer_y;
            item_reg.pan_col <= pan_col_next;
            item_reg.pan_row <= pan_row_next;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/hcp_out_stage.sv
// Cursor clipping, display start address and result register of the cursor positioner.
module hcp_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  hcp_pkg::cfg_t       cfg,
    input  logic                item_valid,
    output logic                item_ready,
    input  hcp_pkg::pan_item_t  item,
    output logic                m_valid,
    input  logic                m_ready,
    output hcp_pkg::out_t       m_data
);

    localparam int CB        = hcp_pkg::COORD_BITS;
    localparam int DIFF_BITS = CB + 2;
    localparam int OW        = (DIFF_BITS > hcp_pkg::ORIGIN_BITS + 1) ?
                               DIFF_BITS : hcp_pkg::ORIGIN_BITS + 1;
    localparam int ROWP_BITS = CB + hcp_pkg::VIRT_BITS;
    localparam int PROD_BITS = ROWP_BITS + 2;
    localparam int COLS_BITS = CB + 2;

    typedef struct packed {
        logic [hcp_pkg::ORIGIN_BITS-1:0] origin;
        logic [hcp_pkg::OFFSET_BITS-1:0] offset;
    } clip_t;

    function automatic clip_t clip_axis(input logic [DIFF_BITS-1:0] d);
        logic [DIFF_BITS-1:0] mag;
        logic [7:0]           m;
        logic [OW-1:0]        pos;
        clip_t                r;
        mag = -d;
        m   = mag[7:0] & hcp_pkg::EVEN_MASK;
        pos = OW'(d);
        if (d[DIFF_BITS-1]) begin
            r.origin = '0;
            r.offset = (m > 8'(hcp_pkg::CURSOR_SIZE - 2)) ?
                       hcp_pkg::OFFSET_BITS'(hcp_pkg::CURSOR_SIZE - 2) :
                       m[hcp_pkg::OFFSET_BITS-1:0];
        end else begin
            r.offset = '0;
            r.origin = (pos > OW'(hcp_pkg::ORIGIN_MAX)) ?
                       hcp_pkg::ORIGIN_BITS'(hcp_pkg::ORIGIN_MAX) :
                       pos[hcp_pkg::ORIGIN_BITS-1:0];
        end
        return r;
    endfunction

    logic                 m_valid_reg;
    hcp_pkg::out_t        m_data_reg;
    hcp_pkg::out_t        result;

    logic [DIFF_BITS-1:0] diff_x, diff_y;
    clip_t                clip_x, clip_y;
    logic [1:0]           bpp_shift;
    logic [ROWP_BITS-1:0] row_prod;
    logic [PROD_BITS-1:0] row_scaled, row_term, start_sum;
    logic [COLS_BITS-1:0] col_scaled, col_term;

    always_comb begin
        case (cfg.pixel_size_code)
            hcp_pkg::PSC_ONE: bpp_shift = 2'd0;
            hcp_pkg::PSC_TWO: bpp_shift = 2'd1;
            default:          bpp_shift = 2'd2;
        endcase
    end

    always_comb begin
        diff_x = DIFF_BITS'(item.x) - DIFF_BITS'(item.pan_col) - DIFF_BITS'(cfg.hot_x);
        diff_y = DIFF_BITS'(item.y) - DIFF_BITS'(item.pan_row) - DIFF_BITS'(cfg.hot_y);
        clip_x = clip_axis(diff_x);
        clip_y = clip_axis(diff_y);

        row_prod   = ROWP_BITS'(item.pan_row) * ROWP_BITS'(cfg.virtual_width);
        row_scaled = PROD_BITS'(row_prod) << bpp_shift;
        row_term   = row_scaled >> 2;
        col_scaled = COLS_BITS'(item.pan_col) << bpp_shift;
        col_term   = col_scaled >> 2;
        start_sum  = row_term + PROD_BITS'(col_term);

        if (item.blocked) begin
            result = '0;
        end else begin
            result.updated        = 1'b1;
            result.origin_x       = clip_x.origin;
            result.origin_y       = clip_y.origin;
            result.start_offset_x = clip_x.offset;
            result.start_offset_y = clip_y.offset;
            result.pan_changed    = item.changed;
            result.display_start  = start_sum[hcp_pkg::START_BITS-1:0];
        end
    end

    assign item_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (item_ready) begin
            m_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_ready && item_valid) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/hw_cursor_position_with_pan_top.sv
// Top level of the hardware cursor positioner with viewport panning.
//
// Usage:
//   s_valid/s_ready/s_data carry one pointer position per transaction.
//   m_valid/m_ready/m_data return exactly one result per input transaction,
//   in order: cursor origin, clipped image offsets, pan-changed flag and the
//   display start address (4-byte units, low 20 bits).
//   cfg_wr_en/cfg_index/cfg_wr_data write the configuration registers;
//   write them only while no transaction is in flight.
// Pipeline: a result passes the pan register, then the result register,
//   before it is presented. Throughput: one transaction per cycle while
//   m_ready stays high; the pan state loop closes within the pan stage.
// Reset (aresetn low, synchronous): pan cleared to 0, registers to their
//   defaults (640x480 visible, 640 pitch, one byte per pixel), pipeline empty.
// Stall: when m_ready is low the result register holds, the pan stage holds
//   once its item cannot move on, and s_ready drops only when both are full.
module hw_cursor_position_with_pan_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  hcp_pkg::in_t                        s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output hcp_pkg::out_t                       m_data,
    input  logic                                cfg_wr_en,
    input  logic [hcp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [hcp_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data
);

    hcp_pkg::cfg_t       cfg;
    hcp_pkg::pan_item_t  pan_item;
    logic                pan_valid;
    logic                pan_ready;

    // Configuration registers: one write per cycle, no read-back
    hcp_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Pan update: move the viewport so the pointer stays visible, hold when blocked
    hcp_pan_stage u_pan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_data    (s_data),
        .item_valid (pan_valid),
        .item_ready (pan_ready),
        .item       (pan_item)
    );

    // Result: subtract pan and hotspot, clip, form the display start address
    hcp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (pan_valid),
        .item_ready (pan_ready),
        .item       (pan_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

>>> rtl/hcp_checker.sv
// Port-level checker of the cursor positioner and its bind to the top level.
module hcp_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input hcp_pkg::in_t   s_data,
    input logic           m_valid,
    input logic           m_ready,
    input hcp_pkg::out_t  m_data
);

    // Hold a stalled input transaction unchanged until it is taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed while stalled");

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Drop every result in flight at reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A blocked result carries nothing but zeros
    a_blocked_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.updated |-> m_data == '0)
        else $error("blocked result not zero");

    // Offsets are even, and a clipped axis puts the origin at zero
    a_clip_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_data.start_offset_x[0] && !m_data.start_offset_y[0]
                    && (m_data.start_offset_x == '0 || m_data.origin_x == '0)
                    && (m_data.start_offset_y == '0 || m_data.origin_y == '0))
        else $error("clip offset and origin inconsistent");

endmodule

bind hw_cursor_position_with_pan_top hcp_checker u_hcp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> bench/hcp_bench_pkg.sv
// Scoreboard class for the cursor positioner bench: pan and cursor predictor plus result checks.
package hcp_bench_pkg;

    import hcp_pkg::*;

    class cursor_scoreboard;
        logic                  blocked;
        logic [HOT_BITS-1:0]   hot_x;
        logic [HOT_BITS-1:0]   hot_y;
        logic [VIS_BITS-1:0]   vis_w;
        logic [VIS_BITS-1:0]   vis_h;
        logic [VIRT_BITS-1:0]  virt_w;
        logic [PSC_BITS-1:0]   psc;
        logic [COORD_BITS-1:0] pan_col;
        logic [COORD_BITS-1:0] pan_row;
        out_t                  cursor_results[$];
        int                    failures;

        function new();
            blocked  = 1'b0;
            hot_x    = '0;
            hot_y    = '0;
            vis_w    = VIS_WIDTH_RESET;
            vis_h    = VIS_HEIGHT_RESET;
            virt_w   = VIRT_WIDTH_RESET;
            psc      = PSC_ONE;
            pan_col  = '0;
            pan_row  = '0;
            failures = 0;
        endfunction

        // Mirror a register write; each register keeps only its own width.
        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_BLOCKED:        blocked = data[0];
                REG_HOT_X:          hot_x   = data[HOT_BITS-1:0];
                REG_HOT_Y:          hot_y   = data[HOT_BITS-1:0];
                REG_VISIBLE_WIDTH:  vis_w   = data[VIS_BITS-1:0];
                REG_VISIBLE_HEIGHT: vis_h   = data[VIS_BITS-1:0];
                REG_VIRTUAL_WIDTH:  virt_w  = data[VIRT_BITS-1:0];
                REG_PIXEL_SIZE:     psc     = data[PSC_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Clamp a screen coordinate: negative goes to 0 with an even image offset.
        function void clip_to_screen(int v, output logic [ORIGIN_BITS-1:0] origin,
                                     output logic [OFFSET_BITS-1:0] offset);
            int m;
            if (v < 0) begin
                m = (-v) & int'(EVEN_MASK);
                if (m > CURSOR_SIZE - 2)
                    m = CURSOR_SIZE - 2;
                origin = '0;
                offset = OFFSET_BITS'(m);
            end else begin
                offset = '0;
                origin = (v > ORIGIN_MAX) ? ORIGIN_BITS'(ORIGIN_MAX) : ORIGIN_BITS'(v);
            end
        endfunction

        function void predict_cursor(in_t p);
            out_t   r;
            int     px;
            int     py;
            int     bpp;
            longint row_bytes;
            longint col_bytes;
            r  = '0;
            px = p.pointer_x;
            py = p.pointer_y;
            if (!blocked) begin
                // Pan checks run in order, each one seeing the pan left by the last.
                if (px < int'(pan_col)) begin
                    pan_col = p.pointer_x;
                    r.pan_changed = 1'b1;
                end
                if (px >= int'(pan_col) + int'(vis_w)) begin
                    pan_col = COORD_BITS'(1 + px - int'(vis_w));
                    r.pan_changed = 1'b1;
                end
                if (py < int'(pan_row)) begin
                    pan_row = p.pointer_y;
                    r.pan_changed = 1'b1;
                end
                if (py >= int'(pan_row) + int'(vis_h)) begin
                    pan_row = COORD_BITS'(1 + py - int'(vis_h));
                    r.pan_changed = 1'b1;
                end
                clip_to_screen(px - int'(pan_col) - int'(hot_x), r.origin_x, r.start_offset_x);
                clip_to_screen(py - int'(pan_row) - int'(hot_y), r.origin_y, r.start_offset_y);
                case (psc)
                    PSC_ONE: bpp = 1;
                    PSC_TWO: bpp = 2;
                    default: bpp = 4;
                endcase
                row_bytes = longint'(pan_row) * longint'(virt_w) * bpp;
                col_bytes = longint'(pan_col) * bpp;
                r.display_start = START_BITS'(row_bytes / 4 + col_bytes / 4);
                r.updated = 1'b1;
            end
            cursor_results.push_back(r);
        endfunction

        function int pending();
            return cursor_results.size();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                failures++;
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (cursor_results.size() == 0) begin
                failures++;
                $error("cursor result arrived with no pending prediction");
                return;
            end
            want = cursor_results.pop_front();
            compare_field("updated",        want.updated,        got.updated);
            compare_field("origin_x",       want.origin_x,       got.origin_x);
            compare_field("origin_y",       want.origin_y,       got.origin_y);
            compare_field("start_offset_x", want.start_offset_x, got.start_offset_x);
            compare_field("start_offset_y", want.start_offset_y, got.start_offset_y);
            compare_field("pan_changed",    want.pan_changed,    got.pan_changed);
            compare_field("display_start",  want.display_start,  got.display_start);
        endfunction

        function void flush_leftover();
            if (cursor_results.size() != 0) begin
                failures++;
                $error("%0d cursor results never arrived", cursor_results.size());
                cursor_results.delete();
            end
        endfunction
    endclass

endpackage

>>> bench/tb_hw_cursor_position_with_pan_top.sv
// Top-level bench for the cursor positioner: clock, reset, drivers, monitor and test sequence.
module tb_hw_cursor_position_with_pan_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hcp_pkg::*;
    import hcp_bench_pkg::*;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    in_t                      s_data;
    logic                     m_valid;
    logic                     m_ready;
    out_t                     m_data;
    logic                     cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data;

    cursor_scoreboard board = new();

    // calm: no idling on either side; hold_cycles: receiver hold-off still to run
    bit calm        = 1'b0;
    int hold_cycles = 0;
    int walk_x      = 0;
    int walk_y      = 0;

    hw_cursor_position_with_pan_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs a handshake.
    initial begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: drop m_ready at random, or hold it off for a counted stretch
    // when the test asks for back-pressure. Drive at the falling edge.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready = 1'b0;
                hold_cycles--;
            end else begin
                m_ready = calm || ($urandom_range(99) >= 23);
            end
        end
    end

    // Monitor: sample at the rising edge and check every accepted result transaction.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                board.check_result(m_data);
        end
    end

    // Idle at random cycle by cycle, then offer one pointer transaction and
    // hold it until accepted.
    task automatic send_pointer(in_t p);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 23) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = p;
        do @(posedge aclk); while (!s_ready);
        board.predict_cursor(p);
    endtask

    task automatic send_xy(int x, int y);
        in_t p;
        p.pointer_x = COORD_BITS'(x);
        p.pointer_y = COORD_BITS'(y);
        send_pointer(p);
    endtask

    // Drop valid and wait for every predicted result, then idle on so that
    // the pipeline is empty before any register changes.
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.pending() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    // Write one register; the write enable stays high across back-to-back writes.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = data;
        @(posedge aclk);
        board.write_reg(idx, data);
    endtask

    task automatic setup(logic [CFG_DATA_BITS-1:0] blk, hx, hy, vw, vh, virt, psc);
        write_reg(REG_BLOCKED,        blk);
        write_reg(REG_HOT_X,          hx);
        write_reg(REG_HOT_Y,          hy);
        write_reg(REG_VISIBLE_WIDTH,  vw);
        write_reg(REG_VISIBLE_HEIGHT, vh);
        write_reg(REG_VIRTUAL_WIDTH,  virt);
        write_reg(REG_PIXEL_SIZE,     psc);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Set junk above a register's width now and then; the block must mask it.
    function automatic logic [CFG_DATA_BITS-1:0] noisy(int value, int width);
        logic [CFG_DATA_BITS-1:0] d;
        d = CFG_DATA_BITS'(value);
        if ($urandom_range(3) == 0)
            d = d | CFG_DATA_BITS'($urandom << width);
        return d;
    endfunction

    // Visible sizes: mostly ordinary, sometimes one line, full 2048, wider than
    // the screen limit, or zero so that the pan wraps.
    function automatic int pick_visible();
        case ($urandom_range(9))
            0:       return 1;
            1:       return 2048;
            2:       return 0;
            3:       return 4095;
            default: return $urandom_range(2048, 1);
        endcase
    endfunction

    task automatic random_setup(bit blk);
        int virt;
        case ($urandom_range(5))
            0:       virt = 1;
            1:       virt = 4096;
            2:       virt = 8191;
            default: virt = $urandom_range(4096, 1);
        endcase
        setup(noisy(blk, 1), noisy($urandom_range(63), HOT_BITS),
              noisy($urandom_range(63), HOT_BITS), noisy(pick_visible(), VIS_BITS),
              noisy(pick_visible(), VIS_BITS), noisy(virt, VIRT_BITS),
              noisy($urandom_range(3), PSC_BITS));
    endtask

    function automatic int step_axis(int pos);
        int np;
        np = pos + int'($urandom_range(160)) - 80;
        if (np < 0)
            np = 0;
        if (np > 4095)
            np = 4095;
        return np;
    endfunction

    // Pointer motion: mostly a short random walk so the pan follows it edge by
    // edge, with jumps across the desktop and hits on the corners mixed in.
    function automatic in_t next_pointer();
        in_t p;
        int  pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            walk_x = $urandom_range(4095);
            walk_y = $urandom_range(4095);
        end else if (pick < 22) begin
            walk_x = $urandom_range(1) * 4095;
            walk_y = $urandom_range(1) * 4095;
        end else begin
            walk_x = step_axis(walk_x);
            walk_y = step_axis(walk_y);
        end
        p.pointer_x = COORD_BITS'(walk_x);
        p.pointer_y = COORD_BITS'(walk_y);
        return p;
    endfunction

    task automatic random_phase(int items, bit blk, bit quiet, bit squeeze);
        calm = quiet;
        settle();
        random_setup(blk);
        for (int i = 0; i < items; i++) begin
            // Hold off the receiver while the sender keeps going, so the
            // pipeline fills and s_ready has to drop.
            if (squeeze && i == 10)
                hold_cycles = 80;
            send_pointer(next_pointer());
        end
    endtask

    initial begin
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        aresetn     = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: corners, a repeat that leaves the pan alone but
        // still reports the display start, and a move back inside.
        send_xy(0, 0);
        send_xy(4095, 4095);
        send_xy(4095, 4095);
        send_xy(0, 4095);
        send_xy(700, 300);

        // Visible size written as 4096, which masks to zero: the pan wraps,
        // the largest hotspot clips past the image and the origin saturates.
        settle();
        setup(0, 63, 63, 13'h1000, 13'h1000, 13'h1000, 3);
        send_xy(0, 0);
        send_xy(4095, 4095);
        send_xy(1234, 2345);

        // Visible wider than the origin range, pitch of one, two bytes per pixel.
        settle();
        setup(0, 0, 0, 4095, 4095, 1, PSC_TWO);
        send_xy(4095, 4095);
        send_xy(0, 0);
        send_xy(4095, 0);

        // Blocked: the pan holds and results come back all zero.
        settle();
        setup(1, 0, 0, 4095, 4095, 1, PSC_TWO);
        send_xy(5, 5);
        send_xy(4095, 0);

        // One-pixel viewport, full pitch, four bytes per pixel.
        settle();
        setup(0, 17, 40, 1, 1, 8191, PSC_FOUR);
        send_xy(0, 0);
        send_xy(4095, 4095);
        send_xy(2048, 1);

        // Random phases: one without idling, one with a long receiver
        // hold-off, one short blocked phase.
        for (int p = 0; p < 9; p++)
            random_phase((p == 6) ? 12 : 82, p == 6, p == 2, p == 4);

        calm = 1'b0;
        settle();
        repeat (8) @(posedge aclk);
        board.flush_leftover();
        if (board.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
